// ----- rtl/core/lkv_pkg.sv -----
// Shared types and constants for the LRU key-value cache.
// No dependencies; used by every module in rtl/core.
`timescale 1ns / 1ps

package lkv_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int CNT_BITS   = 32;
    localparam int CAP_BITS   = 5;
    localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_BITS   = $clog2(ENTRIES + 1);
    localparam int CMP_BITS   = (OCC_BITS > CAP_BITS) ? OCC_BITS : CAP_BITS;

    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

    typedef enum logic [1:0] {
        OP_GET   = 2'd0,
        OP_PUT   = 2'd1,
        OP_FLUSH = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]            operation;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] put_value;
    } t_in_item;

    typedef struct packed {
        logic                  hit;
        logic [31:0]           read_value;
        logic [CNT_BITS-1:0]   hit_count;
        logic [CNT_BITS-1:0]   miss_count;
    } t_out_item;

    // broadcast to every entry; sel picks the target entry
    typedef struct packed {
        logic                  clear;
        logic                  promote;
        logic                  age_all;
        logic                  insert;
        logic                  wr_key;
        logic                  wr_value;
        logic [IDX_BITS-1:0]   old_rank;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } t_slot_cmd;

    typedef struct packed {
        logic clear;
        logic inc_hit;
        logic inc_miss;
    } t_stat_evt;

endpackage

// ----- rtl/core/lkv_slot.sv -----
// One cache entry: key, value, valid bit and recency rank, with key compare.
// Depends on lkv_pkg.
`timescale 1ns / 1ps

module lkv_slot (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lkv_pkg::t_slot_cmd             i_cmd,
    input  logic                           i_sel,
    input  logic [lkv_pkg::KEY_BITS-1:0]   i_cmp_key,
    output logic                           o_valid,
    output logic                           o_match,
    output logic [lkv_pkg::IDX_BITS-1:0]   o_rank,
    output logic [lkv_pkg::VALUE_BITS-1:0] o_value
);

    logic [lkv_pkg::KEY_BITS-1:0]   r_key;
    logic [lkv_pkg::VALUE_BITS-1:0] r_value;
    logic                           r_valid;
    logic [lkv_pkg::IDX_BITS-1:0]   r_rank;
    logic                           n_valid;
    logic [lkv_pkg::IDX_BITS-1:0]   n_rank;

    always_comb begin
        n_valid = r_valid;
        n_rank  = r_rank;
        if (i_cmd.clear) begin
            n_valid = 1'b0;
            n_rank  = '0;
        end else if (i_sel && (i_cmd.promote || i_cmd.insert)) begin
            n_valid = r_valid | i_cmd.insert;
            n_rank  = '0;
        end else if (r_valid &&
                     (i_cmd.age_all || (i_cmd.promote && (r_rank < i_cmd.old_rank)))) begin
            n_rank = r_rank + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else begin
            r_valid <= n_valid;
            r_rank  <= n_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sel && i_cmd.wr_key) begin
            r_key <= i_cmd.key;
        end
        if (i_sel && i_cmd.wr_value) begin
            r_value <= i_cmd.value;
        end
    end

    assign o_valid = r_valid;
    assign o_match = r_valid && (r_key == i_cmp_key);
    assign o_rank  = r_rank;
    assign o_value = r_value;

endmodule

// ----- rtl/core/lkv_stats.sv -----
// Saturating get-hit and get-miss counters.
// Depends on lkv_pkg.
`timescale 1ns / 1ps

module lkv_stats (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lkv_pkg::t_stat_evt           i_evt,
    output logic [lkv_pkg::CNT_BITS-1:0] o_next_hit,
    output logic [lkv_pkg::CNT_BITS-1:0] o_next_miss
);

    logic [lkv_pkg::CNT_BITS-1:0] r_hit;
    logic [lkv_pkg::CNT_BITS-1:0] r_miss;
    logic [lkv_pkg::CNT_BITS-1:0] n_hit;
    logic [lkv_pkg::CNT_BITS-1:0] n_miss;

    always_comb begin
        n_hit  = r_hit;
        n_miss = r_miss;
        if (i_evt.clear) begin
            n_hit  = '0;
            n_miss = '0;
        end else begin
            if (i_evt.inc_hit && !(&r_hit)) begin
                n_hit = r_hit + 1'b1;
            end
            if (i_evt.inc_miss && !(&r_miss)) begin
                n_miss = r_miss + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit  <= '0;
            r_miss <= '0;
        end else begin
            r_hit  <= n_hit;
            r_miss <= n_miss;
        end
    end

    assign o_next_hit  = n_hit;
    assign o_next_miss = n_miss;

endmodule

// ----- rtl/core/lru_key_value_cache.sv -----
// Top level of the fully associative LRU key-value cache.
// Depends on lkv_pkg, lkv_slot and lkv_stats.
`timescale 1ns / 1ps
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------
//  in       | input     | i_in_valid/o_in_stall   | t_in_item
//  out      | output    | o_out_valid/i_out_stall | t_out_item
//  cfg      | input     | i_cfg_valid/o_cfg_ready | capacity, 5 bits
//
//  One item per cycle sustained while the output is not stalled; an accepted item
//  passes through the input register, then one pass of parallel key compare and rank
//  update into the result register, which drives the output.
//  Synchronous active-low reset empties the cache, clears both counters and
//  sets capacity to 16. A stalled result holds the input register; only then
//  is the input stalled. cfg is always ready.

module lru_key_value_cache (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  lkv_pkg::t_in_item              i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output lkv_pkg::t_out_item             o_out_item,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lkv_pkg::CAP_BITS-1:0]   i_cfg_data
);

    localparam int N = lkv_pkg::ENTRIES;

    logic                          r_in_valid;
    lkv_pkg::t_in_item             r_in;
    logic                          r_out_valid;
    lkv_pkg::t_out_item            r_out;
    logic [lkv_pkg::CAP_BITS-1:0]  r_capacity;
    logic [lkv_pkg::OCC_BITS-1:0]  r_occ;
    logic [lkv_pkg::OCC_BITS-1:0]  n_occ;

    logic                          w_go;
    logic                          w_get;
    logic                          w_put;
    logic                          w_flush;
    logic                          w_hit;
    logic                          w_evict;
    logic [lkv_pkg::CAP_BITS-1:0]  w_eff_cap;
    logic [lkv_pkg::OCC_BITS-1:0]  w_occ_m1;
    logic [lkv_pkg::IDX_BITS-1:0]  w_hit_idx;
    logic [lkv_pkg::IDX_BITS-1:0]  w_lru_idx;
    logic [lkv_pkg::IDX_BITS-1:0]  w_target;
    logic                          w_has_target;
    lkv_pkg::t_slot_cmd            w_cmd;
    lkv_pkg::t_stat_evt            w_evt;
    lkv_pkg::t_out_item            w_result;
    logic [lkv_pkg::CNT_BITS-1:0]  w_next_hit;
    logic [lkv_pkg::CNT_BITS-1:0]  w_next_miss;

    logic [N-1:0]                    w_valid;
    logic [N-1:0]                    w_match;
    logic [N-1:0]                    w_sel;
    logic [lkv_pkg::IDX_BITS-1:0]    w_rank  [N];
    logic [lkv_pkg::VALUE_BITS-1:0]  w_value [N];

    // handshake
    assign w_go        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_go;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_capacity  <= lkv_pkg::CAP_RESET;
            r_occ       <= '0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
            end else if (w_go) begin
                r_in_valid <= 1'b0;
            end
            if (w_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_capacity <= i_cfg_data;
            end
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_item;
        end
        if (w_go) begin
            r_out <= w_result;
        end
    end

    // decode
    assign w_get   = w_go && (r_in.operation == lkv_pkg::OP_GET);
    assign w_put   = w_go && (r_in.operation == lkv_pkg::OP_PUT);
    assign w_flush = w_go && (r_in.operation == lkv_pkg::OP_FLUSH);
    assign w_hit   = (w_get || w_put) && (|w_match);

    always_comb begin
        if (r_capacity == '0) begin
            w_eff_cap = lkv_pkg::CAP_BITS'(1);
        end else if (lkv_pkg::CMP_BITS'(r_capacity) > lkv_pkg::CMP_BITS'(N)) begin
            w_eff_cap = lkv_pkg::CAP_BITS'(N);
        end else begin
            w_eff_cap = r_capacity;
        end
    end

    assign w_occ_m1 = r_occ - 1'b1;
    assign w_evict  = lkv_pkg::CMP_BITS'(r_occ) >= lkv_pkg::CMP_BITS'(w_eff_cap);

    // lowest matching entry; entry holding the oldest rank
    always_comb begin
        w_hit_idx = '0;
        w_lru_idx = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_hit_idx = lkv_pkg::IDX_BITS'(i);
            end
            if (w_valid[i] && (w_rank[i] == w_occ_m1[lkv_pkg::IDX_BITS-1:0])) begin
                w_lru_idx = lkv_pkg::IDX_BITS'(i);
            end
        end
    end

    always_comb begin
        w_cmd          = '0;
        w_cmd.key      = r_in.key;
        w_cmd.value    = r_in.put_value;
        w_target       = '0;
        w_has_target   = 1'b0;
        n_occ          = r_occ;
        if (w_flush) begin
            w_cmd.clear = 1'b1;
            n_occ       = '0;
        end else if (w_hit) begin
            w_target       = w_hit_idx;
            w_has_target   = 1'b1;
            w_cmd.promote  = 1'b1;
            w_cmd.old_rank = w_rank[w_hit_idx];
            w_cmd.wr_value = w_put;
        end else if (w_put && w_evict) begin
            w_target       = w_lru_idx;
            w_has_target   = 1'b1;
            w_cmd.promote  = 1'b1;
            w_cmd.old_rank = w_rank[w_lru_idx];
            w_cmd.wr_key   = 1'b1;
            w_cmd.wr_value = 1'b1;
        end else if (w_put) begin
            // valid entries always fill from index zero upward
            w_target       = r_occ[lkv_pkg::IDX_BITS-1:0];
            w_has_target   = 1'b1;
            w_cmd.age_all  = 1'b1;
            w_cmd.insert   = 1'b1;
            w_cmd.wr_key   = 1'b1;
            w_cmd.wr_value = 1'b1;
            n_occ          = r_occ + 1'b1;
        end
    end

    always_comb begin
        for (int i = 0; i < N; i++) begin
            w_sel[i] = w_has_target && (w_target == lkv_pkg::IDX_BITS'(i));
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_slot
        lkv_slot u_slot (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (w_cmd),
            .i_sel     (w_sel[g]),
            .i_cmp_key (r_in.key),
            .o_valid   (w_valid[g]),
            .o_match   (w_match[g]),
            .o_rank    (w_rank[g]),
            .o_value   (w_value[g])
        );
    end

    assign w_evt.clear    = w_flush;
    assign w_evt.inc_hit  = w_get && w_hit;
    assign w_evt.inc_miss = w_get && !w_hit;

    lkv_stats u_stats (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt       (w_evt),
        .o_next_hit  (w_next_hit),
        .o_next_miss (w_next_miss)
    );

    always_comb begin
        w_result            = '0;
        w_result.hit        = w_hit;
        w_result.read_value = (w_get && w_hit) ? 32'(w_value[w_hit_idx]) : '0;
        w_result.hit_count  = w_next_hit;
        w_result.miss_count = w_next_miss;
    end

endmodule

// ----- rtl/core/lkv_checker.sv -----
// Port-level checks for the LRU key-value cache, bound to the top level.
// Depends on lkv_pkg and lru_key_value_cache.
`timescale 1ns / 1ps

module lkv_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         o_in_stall,
    input  logic                         o_out_valid,
    input  logic                         i_out_stall,
    input  lkv_pkg::t_out_item           o_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result item changed");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while output free");

    a_read_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.read_value != '0) |->
            o_out_item.hit && (o_out_item.hit_count != '0))
        else $error("read value without a counted hit");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result item after reset");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

// ----- sim/tb_lru_key_value_cache.sv -----
// Self-checking testbench for lru_key_value_cache: directed table, then random phases.
// Each phase runs at its own capacity setting, with burst/gap sending and patterned stalls.
// Depends on lkv_pkg and the rtl/core sources.
`timescale 1ns / 1ps

module tb_lru_key_value_cache;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    lkv_pkg::t_in_item            in_item = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    lkv_pkg::t_out_item           out_item;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [lkv_pkg::CAP_BITS-1:0] cfg_data = '0;

    lru_key_value_cache uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow copy of the cache
    logic [lkv_pkg::KEY_BITS-1:0]   cache_key [lkv_pkg::ENTRIES];
    logic [lkv_pkg::VALUE_BITS-1:0] cache_val [lkv_pkg::ENTRIES];
    bit                             cache_vld [lkv_pkg::ENTRIES];
    int                             cache_rank [lkv_pkg::ENTRIES];
    int                             cache_occ;
    logic [lkv_pkg::CNT_BITS-1:0]   gets_hit;
    logic [lkv_pkg::CNT_BITS-1:0]   gets_missed;
    logic [lkv_pkg::CAP_BITS-1:0]   cap_reg;

    lkv_pkg::t_out_item             pending_replies [$];
    logic [lkv_pkg::KEY_BITS-1:0]   key_pool [$];
    int                             err_cnt = 0;
    int                             burst_left = 0;

    typedef struct packed {
        lkv_pkg::t_op                   op;
        logic [lkv_pkg::KEY_BITS-1:0]   key;
        logic [lkv_pkg::VALUE_BITS-1:0] val;
        logic                           typed;
        lkv_pkg::t_out_item             reply;
    } t_dir_row;

    localparam int DIR_ROWS = 20;
    localparam logic [31:0] Z = 32'h0;
    localparam logic [31:0] F = 32'hFFFF_FFFF;

    // typed rows hold the reply; the others go to the predictor
    t_dir_row dir_tab [DIR_ROWS] = '{
        '{lkv_pkg::OP_GET,   Z,            Z,            1'b1, '{1'b0, Z, 32'd0, 32'd1}},
        '{lkv_pkg::OP_PUT,   Z,            F,            1'b1, '{1'b0, Z, 32'd0, 32'd1}},
        '{lkv_pkg::OP_GET,   Z,            Z,            1'b1, '{1'b1, F, 32'd1, 32'd1}},
        '{lkv_pkg::OP_PUT,   F,            Z,            1'b1, '{1'b0, Z, 32'd1, 32'd1}},
        '{lkv_pkg::OP_GET,   F,            F,            1'b1, '{1'b1, Z, 32'd2, 32'd1}},
        '{lkv_pkg::OP_PUT,   Z,            32'h5A5A5A5A, 1'b1, '{1'b1, Z, 32'd2, 32'd1}},
        '{lkv_pkg::OP_NONE,  F,            F,            1'b1, '{1'b0, Z, 32'd2, 32'd1}},
        '{lkv_pkg::OP_GET,   Z,            Z,            1'b1,
          '{1'b1, 32'h5A5A5A5A, 32'd3, 32'd1}},
        '{lkv_pkg::OP_GET,   32'hAAAAAAAA, Z,            1'b1, '{1'b0, Z, 32'd3, 32'd2}},
        '{lkv_pkg::OP_FLUSH, F,            F,            1'b1, '{1'b0, Z, 32'd0, 32'd0}},
        '{lkv_pkg::OP_GET,   Z,            Z,            1'b1, '{1'b0, Z, 32'd0, 32'd1}},
        '{lkv_pkg::OP_PUT,   32'h12345678, 32'h87654321, 1'b0, '0},
        '{lkv_pkg::OP_PUT,   32'h55555555, 32'hAAAAAAAA, 1'b0, '0},
        '{lkv_pkg::OP_GET,   32'h12345678, Z,            1'b0, '0},
        '{lkv_pkg::OP_PUT,   Z,            32'h00000001, 1'b0, '0},
        '{lkv_pkg::OP_GET,   32'h55555555, F,            1'b0, '0},
        '{lkv_pkg::OP_NONE,  Z,            Z,            1'b0, '0},
        '{lkv_pkg::OP_GET,   F,            Z,            1'b0, '0},
        '{lkv_pkg::OP_PUT,   32'h12345678, 32'hC3C3C3C3, 1'b0, '0},
        '{lkv_pkg::OP_GET,   32'h12345678, Z,            1'b0, '0}
    };

    task automatic clear_shadow();
        for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
            cache_key[i]  = '0;
            cache_val[i]  = '0;
            cache_vld[i]  = 1'b0;
            cache_rank[i] = 0;
        end
        cache_occ   = 0;
        gets_hit    = '0;
        gets_missed = '0;
    endtask

    task automatic make_recent(input int slot);
        int old;
        old = cache_rank[slot];
        for (int i = 0; i < lkv_pkg::ENTRIES; i++)
            if (cache_vld[i] && i != slot && cache_rank[i] < old)
                cache_rank[i]++;
        cache_rank[slot] = 0;
    endtask

    task automatic predict_cache_op(input lkv_pkg::t_in_item it,
                                    output lkv_pkg::t_out_item r);
        bit found;
        int slot;
        int ecap;
        found = 1'b0;
        slot  = 0;
        r     = '0;
        ecap  = (cap_reg == 0) ? 1 :
                ((cap_reg > lkv_pkg::ENTRIES) ? lkv_pkg::ENTRIES : int'(cap_reg));
        if (it.operation == lkv_pkg::OP_GET || it.operation == lkv_pkg::OP_PUT) begin
            for (int i = 0; i < lkv_pkg::ENTRIES; i++)
                if (!found && cache_vld[i] && cache_key[i] == it.key) begin
                    found = 1'b1;
                    slot  = i;
                end
        end
        if (it.operation == lkv_pkg::OP_GET) begin
            if (found) begin
                r.read_value = cache_val[slot];
                make_recent(slot);
                if (gets_hit != '1) gets_hit++;
            end else if (gets_missed != '1) begin
                gets_missed++;
            end
        end else if (it.operation == lkv_pkg::OP_PUT) begin
            if (found) begin
                cache_val[slot] = it.put_value;
                make_recent(slot);
            end else begin
                if (cache_occ >= ecap) begin
                    slot = -1;
                    for (int i = 0; i < lkv_pkg::ENTRIES; i++)
                        if (cache_vld[i] && (slot < 0 || cache_rank[i] > cache_rank[slot]))
                            slot = i;
                    make_recent(slot);
                end else begin
                    slot = -1;
                    for (int i = 0; i < lkv_pkg::ENTRIES; i++)
                        if (!cache_vld[i] && slot < 0)
                            slot = i;
                    for (int i = 0; i < lkv_pkg::ENTRIES; i++)
                        if (cache_vld[i])
                            cache_rank[i]++;
                    cache_vld[slot]  = 1'b1;
                    cache_rank[slot] = 0;
                    cache_occ++;
                end
                cache_key[slot] = it.key;
                cache_val[slot] = it.put_value;
            end
        end else if (it.operation == lkv_pkg::OP_FLUSH) begin
            clear_shadow();
        end
        r.hit        = found;
        r.hit_count  = gets_hit;
        r.miss_count = gets_missed;
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
        end
    endtask

    // one item, after a gap when the current burst is used up
    task automatic offer_item(input lkv_pkg::t_in_item it, input bit typed,
                              input lkv_pkg::t_out_item typed_reply);
        lkv_pkg::t_out_item r;
        if (burst_left == 0) begin
            idle_cycles($urandom_range(1, 6));
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (in_stall);
        predict_cache_op(it, r);
        pending_replies.push_back(typed ? typed_reply : r);
    endtask

    task automatic wait_drained();
        int spin;
        spin = 0;
        idle_cycles(1);
        while (pending_replies.size() != 0 && spin < 50000) begin
            @(posedge i_clk);
            spin++;
        end
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [lkv_pkg::CAP_BITS-1:0] v);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge i_clk); while (!cfg_ready);
        cap_reg = v;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [lkv_pkg::CAP_BITS-1:0] cap, input int n,
                             input int flush_pct);
        lkv_pkg::t_in_item it;
        int                r;
        int                ecap;
        wait_drained();
        write_capacity(cap);
        ecap = (cap == 0) ? 1 :
               ((cap > lkv_pkg::ENTRIES) ? lkv_pkg::ENTRIES : int'(cap));
        key_pool.delete();
        key_pool.push_back(32'h0);
        key_pool.push_back(32'hFFFF_FFFF);
        repeat (ecap + ecap / 2 + 2) key_pool.push_back($urandom());
        repeat (n) begin
            r = $urandom_range(0, 99);
            it.key       = key_pool[$urandom_range(0, key_pool.size() - 1)];
            it.put_value = $urandom();
            if (r < flush_pct) begin
                it.operation = lkv_pkg::OP_FLUSH;
                it.key       = $urandom();
            end else if (r < flush_pct + 3) begin
                it.operation = lkv_pkg::OP_NONE;
                it.key       = $urandom();
            end else if (r < flush_pct + 8) begin
                it.operation = ($urandom_range(0, 1) == 0) ? lkv_pkg::OP_GET
                                                           : lkv_pkg::OP_PUT;
                it.key       = $urandom();
            end else if (r < 55) begin
                it.operation = lkv_pkg::OP_GET;
            end else begin
                it.operation = lkv_pkg::OP_PUT;
            end
            offer_item(it, 1'b0, '0);
        end
    endtask

    // receiver: stall pattern changes by segment, with a long hold-off now and then
    int rx_cyc = 0;
    int hold_left = 0;
    int seg_left = 0;
    int rx_mode = 0;

    always @(negedge i_clk) begin
        rx_cyc++;
        if (rx_cyc % 900 == 450) hold_left = 90;
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            if (seg_left == 0) begin
                rx_mode  = $urandom_range(0, 3);
                seg_left = $urandom_range(5, 60);
            end
            seg_left--;
            case (rx_mode)
                0: begin
                    out_stall <= 1'b0;
                end
                1: begin
                    out_stall <= ($urandom_range(0, 3) == 0);
                end
                2: begin
                    out_stall <= ($urandom_range(0, 9) < 6);
                end
                default: begin
                    out_stall <= (rx_cyc % 3 == 0);
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_replies.size() == 0) begin
                $error("reply with nothing pending");
                err_cnt++;
            end else begin
                lkv_pkg::t_out_item e;
                e = pending_replies.pop_front();
                if (out_item.hit !== e.hit) begin
                    $error("hit: expected %0d, got %0d", e.hit, out_item.hit);
                    err_cnt++;
                end
                if (out_item.read_value !== e.read_value) begin
                    $error("read_value: expected %h, got %h", e.read_value, out_item.read_value);
                    err_cnt++;
                end
                if (out_item.hit_count !== e.hit_count) begin
                    $error("hit_count: expected %0d, got %0d", e.hit_count, out_item.hit_count);
                    err_cnt++;
                end
                if (out_item.miss_count !== e.miss_count) begin
                    $error("miss_count: expected %0d, got %0d", e.miss_count,
                           out_item.miss_count);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        lkv_pkg::t_in_item it;
        clear_shadow();
        cap_reg = lkv_pkg::CAP_RESET;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            it.operation = dir_tab[i].op;
            it.key       = dir_tab[i].key;
            it.put_value = dir_tab[i].val;
            offer_item(it, dir_tab[i].typed, dir_tab[i].reply);
        end

        // fill at 31 (treated as full size) without flush, then shrink to 2 with it full
        run_phase(5'd31, 220, 0);
        run_phase(5'd2, 200, 1);
        run_phase(5'd1, 180, 2);
        run_phase(5'd0, 180, 2);
        run_phase(5'd17, 220, 2);
        run_phase(5'($urandom_range(3, 15)), 220, 2);
        run_phase(5'd16, 200, 2);
        run_phase(5'd8, 200, 2);

        wait_drained();
        if (pending_replies.size() != 0) begin
            $error("%0d replies never arrived", pending_replies.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
